### hw/rtl/mag_pkg.sv
// mag_pkg: shared widths, configuration register indexes and control bundles
// for the max-average grid relaxation block. Depends on nothing.
package mag_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int COLS_CFG_W = 11;
  localparam int ROWS_CFG_W = 13;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_GRID_COLUMNS = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_GRID_ROWS    = cfg_idx_t'(1);

  // Grid geometry
  localparam int MIN_SIZE    = 3;
  localparam int MAX_ROWS    = 4096;
  localparam int COLS_RESET  = 1024;
  localparam int ROW_W       = 12;
  localparam int COL_PORT_W  = 10;

  // Shift / clear strobes for one window cell
  typedef struct packed {
    logic adv;
    logic clr;
  } tap_ctl_t;

  // Which averages take part in a relaxation, and whether the cell may change
  typedef struct packed {
    logic use_v;
    logic use_h;
    logic apply;
  } relax_ctl_t;

endpackage

### hw/rtl/mag_tap.sv
// mag_tap: one cell of the stencil window chain; holds a word and hands it on.
// Depends on mag_pkg (tap_ctl_t).
module mag_tap #(
  parameter int W = 33
) (
  input  logic              clk,
  input  mag_pkg::tap_ctl_t ctl,
  input  logic [W-1:0]      d,
  output logic [W-1:0]      q
);

  logic [W-1:0] q_r;

  // Clear wins over advance: at a row end the window is emptied, not shifted.
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      q_r <= '0;
    end else if (ctl.adv) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

### hw/rtl/mag_relax.sv
// mag_relax: maximum of the old value and the selected averages, gated by the
// domain flag. Depends on mag_pkg (relax_ctl_t).
module mag_relax #(
  parameter int W = 32
) (
  input  logic signed [W-1:0] old_val,
  input  logic signed [W-1:0] avg_v,
  input  logic signed [W-1:0] avg_h,
  input  mag_pkg::relax_ctl_t ctl,
  output logic signed [W-1:0] new_val
);

  logic signed [W-1:0] cand_v;
  logic signed [W-1:0] cand_h;
  logic signed [W-1:0] best;
  logic                old_ge_v;
  logic                old_ge_h;
  logic                v_ge_h;

  always_comb begin
    cand_v   = ctl.use_v ? avg_v : old_val;
    cand_h   = ctl.use_h ? avg_h : old_val;
    // three compares side by side, then one select
    old_ge_v = old_val >= cand_v;
    old_ge_h = old_val >= cand_h;
    v_ge_h   = cand_v >= cand_h;
    if (old_ge_v && old_ge_h) begin
      best = old_val;
    end else if (v_ge_h) begin
      best = cand_v;
    end else begin
      best = cand_h;
    end
    new_val = ctl.apply ? best : old_val;
  end

endmodule

### hw/rtl/max_average_grid_relaxation.sv
// max_average_grid_relaxation: top level of the streaming relaxation sweep.
// Depends on mag_pkg, mag_tap (window chain) and mag_relax (max select).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in_     | in        | in_valid/in_stall  | cell_value, inside_domain
//   out_    | out       | out_valid/out_stall| new_value, cell_row, cell_col,
//           |           |                    | end_of_grid, last_in_run
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Cycles: one input word per cycle while the output drains one word per cycle
// and out_stall stays low. Rows above the last emit at most one result per input,
// so they keep that pace; the last row emits two results per input from its second
// column on (three on the final cell), so there the single output register
// sets the pace and the input stalls while it drains the earlier results.
// An accepted word is registered in stage 1, then in the output bundle, which a stall can delay.
// Reset sets counters, sizes, the window and pipeline valids only; the line stores
// need no clearing pass, as every entry is written one row before it is read.
// A stalled output holds the result bundle and pushes back through in_stall.
module max_average_grid_relaxation #(
  parameter int MAX_COLUMNS = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [VALUE_WIDTH-1:0]         in_cell_value,
  input  logic                                  in_inside_domain,
  // result stream
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [VALUE_WIDTH-1:0]         out_new_value,
  output logic [mag_pkg::ROW_W-1:0]             out_cell_row,
  output logic [mag_pkg::COL_PORT_W-1:0]        out_cell_col,
  output logic                                  out_end_of_grid,
  output logic                                  out_last_in_run,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mag_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mag_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int VW         = VALUE_WIDTH;
  localparam int COL_W      = $clog2(MAX_COLUMNS);
  localparam int ROW_W      = mag_pkg::ROW_W;
  localparam int COL_PORT_W = mag_pkg::COL_PORT_W;
  localparam logic [31:0] COL_RST_LAST =
    32'(((MAX_COLUMNS < mag_pkg::COLS_RESET) ? MAX_COLUMNS : mag_pkg::COLS_RESET) - 1);
  localparam logic [31:0] ROW_RST_LAST = 32'(mag_pkg::MAX_ROWS - 1);

  // floor((a + b) / 2) on the exact sum one bit wider
  function automatic logic signed [VW-1:0] avg2(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    return s[VW:1];
  endfunction

  // ------------------------------------------------------------------
  // Configuration: store the clamped last column and last row index.
  // ------------------------------------------------------------------
  logic              cfg_wr;
  logic              cols_hit;
  logic              rows_hit;
  logic              restart;
  logic [31:0]       cols32;
  logic [31:0]       rows32;
  logic [31:0]       cols_last32;
  logic [31:0]       rows_last32;
  logic [COL_W-1:0]  col_last_r;
  logic [ROW_W-1:0]  row_last_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_wr   = cfg_valid & cfg_ready;
    cols_hit = 1'b0;
    rows_hit = 1'b0;
    unique case (cfg_index)
      mag_pkg::CFG_GRID_COLUMNS: cols_hit = cfg_wr;
      mag_pkg::CFG_GRID_ROWS:    rows_hit = cfg_wr;
      default: begin
        // unknown index: drop the write
      end
    endcase
    restart = cols_hit | rows_hit;

    cols32 = 32'(cfg_data[mag_pkg::COLS_CFG_W-1:0]);
    rows32 = 32'(cfg_data[mag_pkg::ROWS_CFG_W-1:0]);
    // saturate the sizes to the legal range, then keep size minus one
    if (cols32 < 32'(mag_pkg::MIN_SIZE)) begin
      cols_last32 = 32'(mag_pkg::MIN_SIZE - 1);
    end else if (cols32 > 32'(MAX_COLUMNS)) begin
      cols_last32 = 32'(MAX_COLUMNS - 1);
    end else begin
      cols_last32 = cols32 - 32'd1;
    end
    if (rows32 < 32'(mag_pkg::MIN_SIZE)) begin
      rows_last32 = 32'(mag_pkg::MIN_SIZE - 1);
    end else if (rows32 > 32'(mag_pkg::MAX_ROWS)) begin
      rows_last32 = 32'(mag_pkg::MAX_ROWS - 1);
    end else begin
      rows_last32 = rows32 - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= COL_RST_LAST[COL_W-1:0];
      row_last_r <= ROW_RST_LAST[ROW_W-1:0];
    end else begin
      if (cols_hit) begin
        col_last_r <= cols_last32[COL_W-1:0];
      end
      if (rows_hit) begin
        row_last_r <= rows_last32[ROW_W-1:0];
      end
    end
  end

  // ------------------------------------------------------------------
  // Raster position of the next input word.
  // ------------------------------------------------------------------
  logic              accept;
  logic [COL_W-1:0]  col_r;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic              at_col_last;
  logic              at_row_last;

  always_comb begin
    at_col_last = col_r == col_last_r;
    at_row_last = row_r == row_last_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (at_col_last) begin
        col_nxt = '0;
        row_nxt = at_row_last ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Line stores. Reads are issued at the next position every cycle, so the
  // registered data always matches the column about to be accepted. Port B
  // fetches the right-hand neighbour from the previous row.
  // ------------------------------------------------------------------
  logic [VW:0]       prior_mem [MAX_COLUMNS];
  logic [VW-1:0]     older_mem [MAX_COLUMNS];
  logic [VW:0]       rd_a_r;
  logic [VW-1:0]     rd_b_r;
  logic [VW-1:0]     rd_o_r;
  logic [COL_W-1:0]  rd_b_addr;
  logic signed [VW-1:0] mid;
  logic signed [VW-1:0] up;
  logic signed [VW-1:0] rgt;
  logic              pf;

  assign rd_b_addr = (col_nxt == col_last_r) ? '0 : col_nxt + COL_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      prior_mem[col_r] <= {in_inside_domain, in_cell_value};
      older_mem[col_r] <= mid;
    end
    rd_a_r <= prior_mem[col_nxt];
    rd_b_r <= prior_mem[rd_b_addr][VW-1:0];
    rd_o_r <= older_mem[col_nxt];
  end

  assign mid = rd_a_r[VW-1:0];
  assign pf  = rd_a_r[VW];
  assign up  = rd_o_r;
  assign rgt = rd_b_r;

  // ------------------------------------------------------------------
  // Window chain: previous-row cell one column left, and the last two
  // cells (value with flag) of the current row. Empty it at reset, on a
  // restart and at each row end.
  // ------------------------------------------------------------------
  mag_pkg::tap_ctl_t tap_ctl;
  logic [VW-1:0]     w0;
  logic [VW:0]       w1_q;
  logic [VW:0]       w2_q;
  logic signed [VW-1:0] w1;
  logic signed [VW-1:0] w2;
  logic              w1f;

  assign tap_ctl.adv = accept;
  assign tap_ctl.clr = ~rst_n | restart | (accept & at_col_last);

  mag_tap #(.W(VW)) u_tap_prev (
    .clk (clk),
    .ctl (tap_ctl),
    .d   (mid),
    .q   (w0)
  );

  mag_tap #(.W(VW + 1)) u_tap_cur1 (
    .clk (clk),
    .ctl (tap_ctl),
    .d   ({in_inside_domain, in_cell_value}),
    .q   (w1_q)
  );

  mag_tap #(.W(VW + 1)) u_tap_cur2 (
    .clk (clk),
    .ctl (tap_ctl),
    .d   (w1_q),
    .q   (w2_q)
  );

  assign w1  = w1_q[VW-1:0];
  assign w1f = w1_q[VW];
  assign w2  = w2_q[VW-1:0];

  // ------------------------------------------------------------------
  // Stage 1: averages and the result mask of the accepted word.
  //   bit 0 - the cell above, one row back
  //   bit 1 - last row only: the cell to the left
  //   bit 2 - final cell of the grid, passed through
  // ------------------------------------------------------------------
  logic [2:0]           s1_mask_r;
  logic [2:0]           s1_mask_nxt;
  logic signed [VW-1:0] s1_old1_r;
  logic                 s1_pf_r;
  logic signed [VW-1:0] s1_avgv1_r;
  logic signed [VW-1:0] s1_avgh1_r;
  logic                 s1_usev1_r;
  logic                 s1_useh1_r;
  logic signed [VW-1:0] s1_old2_r;
  logic                 s1_f2_r;
  logic signed [VW-1:0] s1_avgh2_r;
  logic                 s1_useh2_r;
  logic signed [VW-1:0] s1_x_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [COL_W-1:0]     s1_col_r;
  logic                 b_free;

  assign s1_mask_nxt = {at_row_last & at_col_last,
                        at_row_last & (col_r != '0),
                        row_r != '0};

  assign in_stall = (|s1_mask_r) & ~b_free;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_mask_r <= '0;
    end else if (accept) begin
      s1_mask_r <= s1_mask_nxt;
    end else if (b_free) begin
      s1_mask_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_old1_r  <= mid;
      s1_pf_r    <= pf;
      s1_avgv1_r <= avg2(up, in_cell_value);
      s1_avgh1_r <= avg2(w0, rgt);
      s1_usev1_r <= row_r != ROW_W'(1);          // row above is not the top row
      s1_useh1_r <= (col_r != '0) & ~at_col_last;
      s1_old2_r  <= w1;
      s1_f2_r    <= w1f;
      s1_avgh2_r <= avg2(w2, in_cell_value);
      s1_useh2_r <= col_r != COL_W'(1);          // left cell is not the first column
      s1_x_r     <= in_cell_value;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
    end
  end

  // ------------------------------------------------------------------
  // Max selection between stage 1 and the output bundle.
  // ------------------------------------------------------------------
  mag_pkg::relax_ctl_t  rx1_ctl;
  mag_pkg::relax_ctl_t  rx2_ctl;
  logic signed [VW-1:0] rx1_val;
  logic signed [VW-1:0] rx2_val;

  assign rx1_ctl = '{use_v: s1_usev1_r, use_h: s1_useh1_r, apply: s1_pf_r};
  assign rx2_ctl = '{use_v: 1'b0, use_h: s1_useh2_r, apply: s1_f2_r};

  mag_relax #(.W(VW)) u_relax_up (
    .old_val (s1_old1_r),
    .avg_v   (s1_avgv1_r),
    .avg_h   (s1_avgh1_r),
    .ctl     (rx1_ctl),
    .new_val (rx1_val)
  );

  mag_relax #(.W(VW)) u_relax_left (
    .old_val (s1_old2_r),
    .avg_v   (s1_old2_r),
    .avg_h   (s1_avgh2_r),
    .ctl     (rx2_ctl),
    .new_val (rx2_val)
  );

  // ------------------------------------------------------------------
  // Output bundle: up to three results of one input word, drained in order.
  // ------------------------------------------------------------------
  logic [2:0]           b_mask_r;
  logic [2:0]           b_rest;
  logic signed [VW-1:0] b_val0_r;
  logic signed [VW-1:0] b_val1_r;
  logic signed [VW-1:0] b_val2_r;
  logic [ROW_W-1:0]     b_row_r;
  logic [COL_W-1:0]     b_col_r;
  logic [COL_W-1:0]     col_sel;
  logic [COL_W+COL_PORT_W-1:0] col_ext;
  logic                 take;

  always_comb begin
    out_valid       = |b_mask_r;
    out_end_of_grid = 1'b0;
    priority if (b_mask_r[0]) begin
      out_new_value = b_val0_r;
      out_cell_row  = b_row_r - ROW_W'(1);
      col_sel       = b_col_r;
      b_rest        = {b_mask_r[2:1], 1'b0};
    end else if (b_mask_r[1]) begin
      out_new_value = b_val1_r;
      out_cell_row  = b_row_r;
      col_sel       = b_col_r - COL_W'(1);
      b_rest        = {b_mask_r[2], 2'b00};
    end else begin
      out_new_value   = b_val2_r;
      out_cell_row    = b_row_r;
      col_sel         = b_col_r;
      out_end_of_grid = b_mask_r[2];
      b_rest          = '0;
    end
    col_ext         = {{COL_PORT_W{1'b0}}, col_sel};
    out_cell_col    = col_ext[COL_PORT_W-1:0];
    out_last_in_run = b_rest == '0;
    take            = out_valid & ~out_stall;
    b_free          = ~out_valid | (take & (b_rest == '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r <= '0;
    end else if (b_free) begin
      b_mask_r <= s1_mask_r;
    end else if (take) begin
      b_mask_r <= b_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_val0_r <= rx1_val;
      b_val1_r <= rx2_val;
      b_val2_r <= s1_x_r;
      b_row_r  <= s1_row_r;
      b_col_r  <= s1_col_r;
    end
  end

endmodule

### tb/testbench.sv
// testbench: self-checking bench for max_average_grid_relaxation, one relaxation
// sweep per grid streamed in raster order, checked against a built-in predictor.
// Depends on mag_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mag_pkg::*;

  localparam int CELL_W     = 32;
  localparam int LINE_DEPTH = 1024;
  localparam int CLK_HALF   = 5;

  // Hold the block idle this long after the last result before a register
  // write, to cover words still in flight that cause no result.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 10;

  // Cycles with no word accepted on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  localparam int RANDOM_CELLS_PER_MODE = 60;
  localparam int REPORT_CAP            = 200;

  // Indexes with no register behind them: writes there must change nothing
  localparam cfg_idx_t CFG_IDX_SPARE = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_IDX_TOP   = '1;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct {
    cell_t value;
    logic  in_domain;
  } cell_word_t;

  typedef struct packed {
    cell_t                 value;
    logic [ROW_W-1:0]      row;
    logic [COL_PORT_W-1:0] col;
    logic                  grid_end;
    logic                  run_end;
  } relaxed_cell_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid         = 1'b0;
  logic  in_stall;
  cell_t in_cell_value    = '0;
  logic  in_inside_domain = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cell_t                 out_new_value;
  logic [ROW_W-1:0]      out_cell_row;
  logic [COL_PORT_W-1:0] out_cell_col;
  logic                  out_end_of_grid;
  logic                  out_last_in_run;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_GRID_COLUMNS;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always #(CLK_HALF) clk = ~clk;

  max_average_grid_relaxation #(
    .MAX_COLUMNS(LINE_DEPTH),
    .VALUE_WIDTH(CELL_W)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cell_value    (in_cell_value),
    .in_inside_domain (in_inside_domain),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_value    (out_new_value),
    .out_cell_row     (out_cell_row),
    .out_cell_col     (out_cell_col),
    .out_end_of_grid  (out_end_of_grid),
    .out_last_in_run  (out_last_in_run),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bench bookkeeping. Handshake and result counters move by nonblocking
  // assignment so that the stimulus thread, which reads them at the rising
  // edge, always sees the state from before that edge.
  // ---------------------------------------------------------------------------
  cell_word_t    cells_to_send [$];
  relaxed_cell_t relaxed_cells_due [$];

  int unsigned issued_words     = 0;
  int unsigned accepted_words   = 0;
  int unsigned results_expected = 0;
  int unsigned results_seen     = 0;
  int unsigned fault_count      = 0;
  int unsigned idle_cycles      = 0;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: two line buffers of the previous rows, the flags of the
  // previous row, the raster position and a small window along the current row.
  // ---------------------------------------------------------------------------
  cell_t upper_line  [LINE_DEPTH];   // row just above the incoming word
  cell_t second_line [LINE_DEPTH];   // the row above that
  logic  upper_flags [LINE_DEPTH];

  logic [COLS_CFG_W-1:0] cols_setting = COLS_CFG_W'(COLS_RESET);
  logic [ROWS_CFG_W-1:0] rows_setting = ROWS_CFG_W'(MAX_ROWS);

  int unsigned row_pos = 0;
  int unsigned col_pos = 0;
  cell_t       diag_left    = '0;    // upper row, one column to the left
  cell_t       last_val     = '0;    // current row, previous word
  cell_t       prev_val     = '0;    // current row, the word before that
  logic [1:0]  recent_flags = '0;    // bit 0 is the flag of last_val

  function automatic void start_sweep();
    row_pos      = 0;
    col_pos      = 0;
    diag_left    = '0;
    last_val     = '0;
    prev_val     = '0;
    recent_flags = '0;
  endfunction

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  // floor((a + b) / 2) on the full 33-bit sum, so it never overflows
  function automatic cell_t mean_floor(cell_t a, cell_t b);
    logic [CELL_W:0] sum;
    sum = {a[CELL_W-1], a} + {b[CELL_W-1], b};
    return sum[CELL_W:1];
  endfunction

  function automatic cell_t larger(cell_t a, cell_t b);
    return (a > b) ? a : b;
  endfunction

  // New value of one cell from its old value and its four neighbours
  function automatic cell_t relaxed(cell_t old, logic may_change,
                                    int unsigned row, int unsigned col,
                                    int unsigned rows, int unsigned cols,
                                    cell_t left, cell_t right,
                                    cell_t up, cell_t down);
    cell_t v;
    logic  side_col;
    side_col = (col == 0) || (col == cols - 1);
    v = old;
    if (row == 0 || row == rows - 1) begin
      // top and bottom rows: horizontal only, corners untouched
      if (!side_col) v = larger(old, mean_floor(left, right));
    end else begin
      v = larger(old, mean_floor(up, down));
      if (!side_col) v = larger(v, mean_floor(left, right));
    end
    return may_change ? v : old;
  endfunction

  // Take one accepted word, queue the cells it completes, advance the state
  function automatic int unsigned relax_cell(cell_t x, logic f);
    int unsigned   cols, rows, r, c, n, k;
    cell_t         mid, up, rgt;
    logic          pf;
    relaxed_cell_t done [3];
    cols = clamp_size(32'(cols_setting), LINE_DEPTH);
    rows = clamp_size(32'(rows_setting), MAX_ROWS);
    if (row_pos >= rows || col_pos >= cols) start_sweep();
    r   = row_pos;
    c   = col_pos;
    n   = 0;
    mid = upper_line[c];
    up  = second_line[c];
    pf  = upper_flags[c];
    rgt = (c + 1 < cols) ? upper_line[c + 1] : '0;

    // the cell above is now complete: its lower neighbour has arrived
    if (r >= 1) begin
      done[n] = '{relaxed(mid, pf, r - 1, c, rows, cols, diag_left, rgt, up, x),
                  ROW_W'(r - 1), COL_PORT_W'(c), 1'b0, 1'b0};
      n++;
    end
    // in the last row the left neighbour completes once its right one is in
    if (r == rows - 1 && c >= 1) begin
      done[n] = '{relaxed(last_val, recent_flags[0], r, c - 1, rows, cols,
                          prev_val, x, '0, '0),
                  ROW_W'(r), COL_PORT_W'(c - 1), 1'b0, 1'b0};
      n++;
    end
    // the closing corner is passed through as it is
    if (r == rows - 1 && c == cols - 1) begin
      done[n] = '{x, ROW_W'(r), COL_PORT_W'(c), 1'b1, 1'b0};
      n++;
    end
    if (n > 0) done[n - 1].run_end = 1'b1;
    for (k = 0; k < n; k++) relaxed_cells_due.push_back(done[k]);

    second_line[c] = mid;
    upper_line[c]  = x;
    upper_flags[c] = f;
    diag_left      = mid;
    prev_val       = last_val;
    last_val       = x;
    recent_flags   = {recent_flags[0], f};

    if (c + 1 < cols) begin
      col_pos = c + 1;
    end else begin
      col_pos      = 0;
      diag_left    = '0;
      last_val     = '0;
      prev_val     = '0;
      recent_flags = '0;
      row_pos      = (r + 1 < rows) ? r + 1 : 0;
    end
    return n;
  endfunction

  // Register write: unknown indexes are dropped, known ones restart the sweep
  function automatic void apply_setting(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GRID_COLUMNS: begin
        cols_setting = data[COLS_CFG_W-1:0];
        start_sweep();
      end
      CFG_GRID_ROWS: begin
        rows_setting = data[ROWS_CFG_W-1:0];
        start_sweep();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next pending word at the falling edge, hold it while
  // stalled, and leave random gaps between words.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feeder
    cell_word_t w;
    if (!(in_valid && issued_words != accepted_words)) begin
      if (cells_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        w = cells_to_send.pop_front();
        in_valid         <= 1'b1;
        in_cell_value    <= w.value;
        in_inside_domain <= w.in_domain;
        issued_words     <= issued_words + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge feed accepted configuration and input words
  // to the predictor, and check each accepted result against the oldest one due.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    relaxed_cell_t got;
    relaxed_cell_t want;
    int unsigned   produced;
    produced = 0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        produced = relax_cell(in_cell_value, in_inside_domain);
        accepted_words <= accepted_words + 1;
      end
      if (out_valid && !out_stall) begin
        got = '{out_new_value, out_cell_row, out_cell_col,
                out_end_of_grid, out_last_in_run};
        results_seen <= results_seen + 1;
        if (relaxed_cells_due.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_CAP)
            $display("%0t: unexpected result: value %h row %0d col %0d end %b last %b",
                     $time, got.value, got.row, got.col, got.grid_end, got.run_end);
        end else begin
          want = relaxed_cells_due.pop_front();
          if (got !== want) begin
            fault_count++;
            if (fault_count <= REPORT_CAP)
              $display({"%0t: mismatch: expected value %h row %0d col %0d end %b last %b,",
                        " got value %h row %0d col %0d end %b last %b"},
                       $time, want.value, want.row, want.col, want.grid_end,
                       want.run_end, got.value, got.row, got.col, got.grid_end,
                       got.run_end);
          end
        end
      end
      results_expected <= results_expected + produced;
    end
  end

  // Watchdog: end the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cell(cell_t v, logic f);
    cells_to_send.push_back('{v, f});
  endfunction

  // Mostly full-range values, with extremes and values near zero mixed in
  function automatic cell_t random_cell_value();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return '1;
          3:       return '0;
          default: return 32'sh0000_0001;
        endcase
      end
      1:       return cell_t'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
      default: return cell_t'($urandom());
    endcase
  endfunction

  function automatic void queue_random_cells(int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++)
      queue_cell(random_cell_value(), $urandom_range(0, 4) != 0);
  endfunction

  // Wait until every word is in and every result out, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk);
    while (cells_to_send.size() != 0 || issued_words != accepted_words ||
           results_expected != results_seen);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [CFG_DATA_W-1:0] cols, logic [CFG_DATA_W-1:0] rows);
    write_register(CFG_GRID_COLUMNS, cols);
    write_register(CFG_GRID_ROWS, rows);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode, mode_cells, cols_data, rows_data, grids, n, k;

    for (k = 0; k < LINE_DEPTH; k++) begin
      upper_line[k]  = '0;
      second_line[k] = '0;
      upper_flags[k] = 1'b0;
    end
    start_sweep();

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct   = 17;
    recv_stall_pct = 83;

    // Sizes below the minimum clamp to a 3x3 grid: one interior cell, the
    // extreme values around it so both averages hit the range limits, and a
    // fixed cell in the bottom row.
    set_grid(13'd2, 13'd1);
    queue_cell(32'sh8000_0000, 1'b1); queue_cell(32'sh7FFF_FFFF, 1'b1);
    queue_cell(32'sh8000_0000, 1'b1);
    queue_cell(32'sh7FFF_FFFF, 1'b1); queue_cell(32'sh8000_0000, 1'b1);
    queue_cell(32'sh7FFF_FFFF, 1'b1);
    queue_cell(32'sh8000_0000, 1'b0); queue_cell(32'sh7FFF_FFFF, 1'b1);
    queue_cell(32'sh0000_0001, 1'b1);
    wait_idle();

    // 4x4 grid: odd sums that round towards minus infinity, fixed interior
    // and edge cells, and fixed cells along the bottom row.
    set_grid(13'd4, 13'd4);
    queue_cell(32'sh0000_0001, 1'b1); queue_cell(32'shFFFF_FFFF, 1'b1);
    queue_cell(32'sh0000_0000, 1'b1); queue_cell(32'sh7FFF_FFFF, 1'b1);
    queue_cell(32'shFFFF_0000, 1'b1); queue_cell(32'sh0001_0000, 1'b1);
    queue_cell(32'sh8000_0000, 1'b0); queue_cell(32'sh0000_0002, 1'b1);
    queue_cell(32'sh7FFF_FFFF, 1'b1); queue_cell(32'sh8000_0000, 1'b1);
    queue_cell(32'shFFFF_FFFE, 1'b1); queue_cell(32'sh8000_0001, 1'b0);
    queue_cell(32'sh0000_0000, 1'b0); queue_cell(32'shFFFF_FFFF, 1'b1);
    queue_cell(32'sh0000_0001, 1'b0); queue_cell(32'sh7FFF_FFFE, 1'b1);
    wait_idle();

    // Three idling modes: slow receiver, then slow sender, then full rate
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_gap_pct   = 17;
          recv_stall_pct = 83;
        end
        1: begin
          send_gap_pct   = 83;
          recv_stall_pct = 17;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      mode_cells = 0;

      case (mode)
        0: begin
          // stop part way into a sweep; the next size write must restart it
          cols_data = $urandom_range(4, 9);
          rows_data = $urandom_range(4, 7);
          set_grid(CFG_DATA_W'(cols_data), CFG_DATA_W'(rows_data));
          queue_random_cells(2 * cols_data + 2);
          wait_idle();
        end
        1: begin
          // row count beyond the limit clamps to the tallest grid; run a slice
          set_grid(13'd3, 13'h1FFF);
          queue_random_cells(40);
          wait_idle();
          // writes to unused indexes mid-sweep must leave the sweep running
          set_grid(13'd6, 13'd5);
          queue_random_cells(14);
          wait_idle();
          write_register(CFG_IDX_SPARE, CFG_DATA_W'($urandom()));
          write_register(CFG_IDX_TOP, CFG_DATA_W'($urandom()));
          queue_random_cells(16);
          wait_idle();
        end
        default: begin
          // data bits above the column field are dropped: this reads as five
          set_grid(13'h1805, 13'd3);
          queue_random_cells(15);
          wait_idle();
        end
      endcase

      // Random small grids, one or two sweeps back to back per setting
      while (mode_cells < RANDOM_CELLS_PER_MODE) begin
        cols_data = $urandom_range(1, 10);
        rows_data = $urandom_range(2, 8);
        grids     = $urandom_range(1, 2);
        set_grid(CFG_DATA_W'(cols_data), CFG_DATA_W'(rows_data));
        n = clamp_size(cols_data, LINE_DEPTH) * clamp_size(rows_data, MAX_ROWS) * grids;
        queue_random_cells(n);
        mode_cells += n;
        wait_idle();
      end
    end

    // Drain, allow for stray late results, then judge
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (relaxed_cells_due.size() != 0) begin
      fault_count++;
      $display("%0t: %0d results never arrived, first expected value %h row %0d col %0d",
               $time, relaxed_cells_due.size(), relaxed_cells_due[0].value,
               relaxed_cells_due[0].row, relaxed_cells_due[0].col);
    end
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mag_pkg.sv
hw/rtl/mag_tap.sv
hw/rtl/mag_relax.sv
hw/rtl/max_average_grid_relaxation.sv
tb/testbench.sv
